/* sv/ctt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants of the connection table tracker.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int DEFAULT_NUM_SLOTS = 32;

  localparam int ID_W     = 64;
  localparam int TYPE_W   = 8;
  localparam int SEQ_W    = 32;
  localparam int ACTION_W = 4;
  localparam int SLOT_W   = 5;

  localparam logic [TYPE_W-1:0] TYPE_HANDSHAKE = 8'h01;
  localparam logic [TYPE_W-1:0] TYPE_DATA      = 8'h03;
  localparam logic [TYPE_W-1:0] TYPE_ACK       = 8'h04;
  localparam logic [TYPE_W-1:0] TYPE_CLOSE     = 8'h05;

  localparam logic [SEQ_W-1:0] SEQ_START = 32'd1;

  typedef enum logic [2:0] {
    KIND_HANDSHAKE = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_ACK       = 3'd2,
    KIND_CLOSE     = 3'd3,
    KIND_UNKNOWN   = 3'd4
  } kind_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NO_SESSION = 4'd0,
    ACT_NEW        = 4'd1,
    ACT_FULL       = 4'd2,
    ACT_REHANDS    = 4'd3,
    ACT_DUP        = 4'd4,
    ACT_INORDER    = 4'd5,
    ACT_GAP        = 4'd6,
    ACT_ACK        = 4'd7,
    ACT_CLOSED     = 4'd8,
    ACT_UNKNOWN    = 4'd9
  } action_e;

  typedef struct packed {
    logic [ID_W-1:0]  conn_id;
    kind_e            kind;
    logic [SEQ_W-1:0] seq_num;
  } item_t;

endpackage
`default_nettype wire

/* sv/connection_table_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// connection_table_tracker
// Connection slot table: lookup, allocate, sequence check and close per
// decoded packet header.
// ----------------------------------------------------------------------------
// The result is registered after the accepted beat has passed the input queue
// and the compare, encode and update steps of the back end, which handles one
// header at a time; output back-pressure can hold the update step.
// The two-entry input queue accepts beats while the back end works.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module connection_table_tracker import ctt_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ID_W-1:0]     conn_id_i,
  input  wire logic [TYPE_W-1:0]   packet_type_i,
  input  wire logic [SEQ_W-1:0]    seq_num_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [ACTION_W-1:0]      action_o,
  output logic [SLOT_W-1:0]        slot_index_o,
  output logic [SEQ_W-1:0]         reply_seq_o
);

  logic  item_valid;
  item_t item;
  logic  item_pop;

  ctt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .conn_id_i     (conn_id_i),
    .packet_type_i (packet_type_i),
    .seq_num_i     (seq_num_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  ctt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .slot_index_o (slot_index_o),
    .reply_seq_o  (reply_seq_o)
  );

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("queue popped while empty");

  a_accept_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> item_valid)
    else $error("accepted beat missing from queue");

  a_reply_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_DUP && action_o != ACT_INORDER
      && action_o != ACT_GAP |-> reply_seq_o == '0)
    else $error("reply sequence on non-data result");

  a_unknown_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_UNKNOWN |-> slot_index_o == '0)
    else $error("slot reported for unknown type");

endmodule
`default_nettype wire

/* sv/ctt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/ctt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_front
// Input side: decode the type byte and hold headers in a two-entry queue.
// ----------------------------------------------------------------------------
module ctt_front import ctt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ID_W-1:0]   conn_id_i,
  input  wire logic [TYPE_W-1:0] packet_type_i,
  input  wire logic [SEQ_W-1:0]  seq_num_i,
  output logic                   item_valid_o,
  output item_t                  item_o,
  input  wire logic              item_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  kind_e       kind;
  logic        push, pop;

  always_comb begin
    unique case (packet_type_i)
      TYPE_HANDSHAKE: kind = KIND_HANDSHAKE;
      TYPE_DATA:      kind = KIND_DATA;
      TYPE_ACK:       kind = KIND_ACK;
      TYPE_CLOSE:     kind = KIND_CLOSE;
      default:        kind = KIND_UNKNOWN;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{conn_id: conn_id_i, kind: kind, seq_num: seq_num_i};
    end
  end

endmodule
`default_nettype wire

/* sv/ctt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_back
// Execution side: match against the slot table, pick the slot, update the
// table and register one result per header.
// ----------------------------------------------------------------------------
module ctt_back import ctt_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS,
  localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  input  wire item_t               item_i,
  output logic                     item_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [ACTION_W-1:0]      action_o,
  output logic [SLOT_W-1:0]        slot_index_o,
  output logic [SEQ_W-1:0]         reply_seq_o
);

  typedef enum logic [2:0] {
    ST_CMP  = 3'b001,
    ST_ENC  = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  item_t                  item_q;
  logic [NUM_SLOTS-1:0]   valid_q;
  logic [ID_W-1:0]        id_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   match_q, free_q, match_d;
  logic                   hit_q, free_any_q;
  logic [IDX_W-1:0]       hit_idx_q, free_idx_q, hit_idx, free_idx;
  logic [SEQ_W-1:0]       exp_seq;

  logic                   out_valid_q;
  action_e                action_q, action_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [SEQ_W-1:0]       reply_q, reply_d;

  logic                   exec_go;
  logic                   alloc, release_slot;
  logic                   seq_we;
  logic [IDX_W-1:0]       seq_waddr;
  logic [SEQ_W-1:0]       seq_wdata;

  function automatic logic [IDX_W-1:0] lowest_idx(input logic [NUM_SLOTS-1:0] vec);
    logic [NUM_SLOTS-1:0] lo;
    logic [IDX_W-1:0]     idx;
    lo  = vec & (~vec + NUM_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      idx = idx | (IDX_W'(i) & {IDX_W{lo[i]}});
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_d[i] = valid_q[i] && (id_q[i] == item_i.conn_id);
    end
  end

  assign hit_idx    = lowest_idx(match_q);
  assign free_idx   = lowest_idx(free_q);
  assign item_pop_o = (state_q == ST_CMP) && item_valid_i;
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  ctt_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (NUM_SLOTS)
  ) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (seq_waddr),
    .wdata_i (seq_wdata),
    .re_i    (state_q == ST_ENC),
    .raddr_i (hit_idx),
    .rdata_o (exp_seq)
  );

  always_comb begin
    action_d     = ACT_NO_SESSION;
    slot_d       = '0;
    reply_d      = '0;
    alloc        = 1'b0;
    release_slot = 1'b0;
    seq_we       = 1'b0;
    seq_waddr    = hit_idx_q;
    seq_wdata    = SEQ_W'(item_q.seq_num + SEQ_W'(1));
    unique case (item_q.kind)
      KIND_HANDSHAKE: begin
        if (hit_q) begin
          action_d = ACT_REHANDS;
          slot_d   = SLOT_W'(hit_idx_q);
        end else if (free_any_q) begin
          action_d  = ACT_NEW;
          slot_d    = SLOT_W'(free_idx_q);
          alloc     = 1'b1;
          seq_we    = exec_go;
          seq_waddr = free_idx_q;
          seq_wdata = SEQ_START;
        end else begin
          action_d = ACT_FULL;
        end
      end
      KIND_DATA: begin
        if (hit_q) begin
          slot_d  = SLOT_W'(hit_idx_q);
          reply_d = item_q.seq_num;
          if (item_q.seq_num < exp_seq) begin
            action_d = ACT_DUP;
          end else begin
            action_d = (item_q.seq_num == exp_seq) ? ACT_INORDER : ACT_GAP;
            seq_we   = exec_go;
          end
        end
      end
      KIND_ACK: begin
        if (hit_q) begin
          action_d = ACT_ACK;
          slot_d   = SLOT_W'(hit_idx_q);
        end
      end
      KIND_CLOSE: begin
        if (hit_q) begin
          action_d     = ACT_CLOSED;
          slot_d       = SLOT_W'(hit_idx_q);
          release_slot = 1'b1;
        end
      end
      default: begin
        action_d = ACT_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CMP:  if (item_valid_i) state_d = ST_ENC;
      ST_ENC:  state_d = ST_EXEC;
      ST_EXEC: if (exec_go) state_d = ST_CMP;
      default: state_d = ST_CMP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CMP;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go && alloc) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (exec_go && release_slot) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q  <= item_i;
      match_q <= match_d;
      free_q  <= ~valid_q;
    end
    if (state_q == ST_ENC) begin
      hit_q      <= |match_q;
      free_any_q <= |free_q;
      hit_idx_q  <= hit_idx;
      free_idx_q <= free_idx;
    end
    if (exec_go && alloc) begin
      id_q[free_idx_q] <= item_q.conn_id;
    end
    if (exec_go) begin
      action_q <= action_d;
      slot_q   <= slot_d;
      reply_q  <= reply_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = action_q;
  assign slot_index_o = slot_q;
  assign reply_seq_o  = reply_q;

endmodule
`default_nettype wire

/* tb/sv/connection_table_tracker_check.sv */
// ----------------------------------------------------------------------------
// connection_table_tracker_check
// Watches both channels of the connection table tracker. It keeps its own
// copy of the slot table, predicts the verdict for every accepted header,
// and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module connection_table_tracker_check import ctt_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic [ID_W-1:0]     conn_id_i,
  input  wire logic [TYPE_W-1:0]   packet_type_i,
  input  wire logic [SEQ_W-1:0]    seq_num_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [SLOT_W-1:0]   slot_index_i,
  input  wire logic [SEQ_W-1:0]    reply_seq_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_e           action;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  reply;
  } verdict_t;

  logic             slot_live [NUM_SLOTS];
  logic [ID_W-1:0]  slot_id   [NUM_SLOTS];
  logic [SEQ_W-1:0] slot_next [NUM_SLOTS];
  verdict_t         expected_verdicts [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_id[i]   = '0;
      slot_next[i] = '0;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic verdict_t track_header(input logic [ID_W-1:0] id,
                                            input logic [TYPE_W-1:0] ptype,
                                            input logic [SEQ_W-1:0] seq);
    verdict_t v;
    int       hit;
    int       free_slot;
    v.action  = ACT_NO_SESSION;
    v.slot    = '0;
    v.reply   = '0;
    hit       = -1;
    free_slot = -1;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_id[i] == id) hit = i;
      if (!slot_live[i]) free_slot = i;
    end
    case (ptype)
      TYPE_HANDSHAKE: begin
        if (hit >= 0) begin
          v.action = ACT_REHANDS;
          v.slot   = hit[SLOT_W-1:0];
        end else if (free_slot < 0) begin
          v.action = ACT_FULL;
        end else begin
          slot_live[free_slot] = 1'b1;
          slot_id[free_slot]   = id;
          slot_next[free_slot] = SEQ_START;
          v.action = ACT_NEW;
          v.slot   = free_slot[SLOT_W-1:0];
        end
      end
      TYPE_DATA: begin
        if (hit >= 0) begin
          v.slot  = hit[SLOT_W-1:0];
          v.reply = seq;
          if (seq < slot_next[hit]) begin
            v.action = ACT_DUP;
          end else begin
            v.action = (seq == slot_next[hit]) ? ACT_INORDER : ACT_GAP;
            slot_next[hit] = seq + SEQ_W'(1);
          end
        end
      end
      TYPE_ACK: begin
        if (hit >= 0) begin
          v.action = ACT_ACK;
          v.slot   = hit[SLOT_W-1:0];
        end
      end
      TYPE_CLOSE: begin
        if (hit >= 0) begin
          v.action = ACT_CLOSED;
          v.slot   = hit[SLOT_W-1:0];
          slot_live[hit] = 1'b0;
        end
      end
      default: begin
        v.action = ACT_UNKNOWN;
      end
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected: action %0d slot %0d",
                                    action_i, slot_index_i));
        end else begin
          want = expected_verdicts.pop_front();
          if (action_i !== want.action)
            report_mismatch($sformatf("action %0d, expected %0d", action_i, want.action));
          if (slot_index_i !== want.slot)
            report_mismatch($sformatf("slot_index %0d, expected %0d",
                                      slot_index_i, want.slot));
          if (reply_seq_i !== want.reply)
            report_mismatch($sformatf("reply_seq %h, expected %h", reply_seq_i, want.reply));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_verdicts.push_back(track_header(conn_id_i, packet_type_i, seq_num_i));
      pending_o = expected_verdicts.size();
    end
  end

endmodule

/* tb/sv/connection_table_tracker_test.sv */
// ----------------------------------------------------------------------------
// connection_table_tracker_test
// Drives packet headers into the connection table tracker: a directed
// sweep of sessions, sequence classes and field extremes, then random
// traffic over a pool of ids larger than the table, with random stalls on
// both channels. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module connection_table_tracker_test import ctt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_IDS   = 40;
  localparam int RAND_BEATS = 500;
  localparam logic [ID_W-1:0] ID_ONES = '1;
  localparam logic [ID_W-1:0] ID_ALT  = 64'h5555_5555_AAAA_AAAA;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ID_W-1:0]     conn_id_i;
  logic [TYPE_W-1:0]   packet_type_i;
  logic [SEQ_W-1:0]    seq_num_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ACTION_W-1:0] action_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [SEQ_W-1:0]    reply_seq_o;
  int                  fail_count;
  int                  pending;
  bit                  quiet;

  logic [ID_W-1:0]  id_pool  [POOL_IDS];
  logic [SEQ_W-1:0] seq_hint [POOL_IDS];

  connection_table_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .conn_id_i    (conn_id_i),
    .packet_type_i(packet_type_i),
    .seq_num_i    (seq_num_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .slot_index_o (slot_index_o),
    .reply_seq_o  (reply_seq_o)
  );

  connection_table_tracker_check check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .conn_id_i    (conn_id_i),
    .packet_type_i(packet_type_i),
    .seq_num_i    (seq_num_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_i     (action_o),
    .slot_index_i (slot_index_o),
    .reply_seq_i  (reply_seq_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk_i) out_ready_i <= quiet || ($urandom_range(0, 99) >= 37);

  task automatic send_header(input logic [ID_W-1:0] id, input logic [TYPE_W-1:0] ptype,
                             input logic [SEQ_W-1:0] seq);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    conn_id_i     <= id;
    packet_type_i <= ptype;
    seq_num_i     <= seq;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int               k;
    int               r;
    logic [ID_W-1:0]  id;
    logic [TYPE_W-1:0] ptype;
    logic [SEQ_W-1:0] seq;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    conn_id_i     = '0;
    packet_type_i = '0;
    seq_num_i     = '0;
    out_ready_i   = 1'b0;
    quiet         = 1'b0;
    id_pool[0] = '0;
    id_pool[1] = ID_ONES;
    for (int i = 2; i < POOL_IDS; i++) id_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < POOL_IDS; i++) seq_hint[i] = SEQ_START;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // no session yet, and unknown type bytes
    send_header(ID_ALT, TYPE_DATA, 32'd7);
    send_header(ID_ALT, TYPE_ACK, 32'd0);
    send_header(ID_ALT, TYPE_CLOSE, '1);
    send_header(ID_ALT, 8'h00, '1);
    send_header(ID_ONES, 8'hFF, 32'd1);
    send_header('0, 8'h02, 32'd0);
    // open, re-handshake, sequence classes and wrap
    send_header('0, TYPE_HANDSHAKE, 32'd0);
    send_header(ID_ONES, TYPE_HANDSHAKE, '1);
    send_header('0, TYPE_HANDSHAKE, 32'd9);
    send_header('0, TYPE_DATA, 32'd1);
    send_header('0, TYPE_DATA, 32'd1);
    send_header('0, TYPE_DATA, 32'd0);
    send_header('0, TYPE_DATA, '1);
    send_header('0, TYPE_DATA, 32'd0);
    send_header(ID_ONES, TYPE_DATA, 32'd100);
    send_header(ID_ONES, TYPE_ACK, 32'd55);
    send_header(ID_ONES, 8'hFE, 32'd3);
    // close frees the lowest slot for reuse
    send_header('0, TYPE_CLOSE, 32'd0);
    send_header('0, TYPE_DATA, 32'd5);
    send_header(ID_ALT, TYPE_HANDSHAKE, 32'd0);
    send_header(ID_ALT, TYPE_DATA, 32'd1);
    send_header(ID_ALT, TYPE_CLOSE, 32'd0);
    send_header(ID_ONES, TYPE_CLOSE, 32'd0);

    for (int n = 0; n < RAND_BEATS; n++) begin
      quiet = (n >= 200 && n < 300);
      k     = $urandom_range(0, POOL_IDS - 1);
      id    = id_pool[k];
      seq   = $urandom;
      r     = $urandom_range(0, 99);
      if (r < 22) begin
        ptype = TYPE_HANDSHAKE;
        seq_hint[k] = SEQ_START;
      end else if (r < 70) begin
        ptype = TYPE_DATA;
        r = $urandom_range(0, 99);
        if (r < 60) seq = seq_hint[k];
        else if (r < 75) seq = seq_hint[k] - $urandom_range(1, 3);
        else if (r < 90) seq = seq_hint[k] + $urandom_range(1, 1000);
        if (seq >= seq_hint[k]) seq_hint[k] = seq + SEQ_W'(1);
      end else if (r < 80) begin
        ptype = TYPE_ACK;
      end else if (r < 92) begin
        ptype = TYPE_CLOSE;
      end else begin
        ptype = TYPE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) id = {$urandom, $urandom};
      end
      send_header(id, ptype, seq);
    end
    quiet = 1'b0;
    @(negedge clk_i) in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
